// ----- hw/rtl/gmps_pkg.sv -----
package gmps_pkg;

    localparam int GRID_DIM_DEF = 32;
    localparam int SPAN_MAX     = 32;
    localparam int STORE_DEPTH  = 1024;
    localparam int STORE_AW     = 10;
    localparam int LABEL_W      = 11;
    localparam logic [LABEL_W-1:0] LABEL_BASE = 11'd2;
    localparam logic [LABEL_W-1:0] LABEL_OPEN = 11'd0;

    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_RUN    = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [1:0] DIR_RIGHT = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_UP    = 2'd3;

    localparam logic [2:0] CFG_NUM_ROWS  = 3'd0;
    localparam logic [2:0] CFG_NUM_COLS  = 3'd1;
    localparam logic [2:0] CFG_START_ROW = 3'd2;
    localparam logic [2:0] CFG_START_COL = 3'd3;
    localparam logic [2:0] CFG_END_ROW   = 3'd4;
    localparam logic [2:0] CFG_END_COL   = 3'd5;
    localparam logic [2:0] CFG_MODE      = 3'd6;

endpackage

// ----- hw/rtl/gmps_ram.sv -----
module gmps_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 10
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/grid_maze_path_search_unit.sv -----
// A cell write or status request is answered from the result register; a valid path
// read first passes through ST_PATH_RD for the path memory read. A run visits ST_PR_RD
// and ST_PR_CHK per in-grid neighbor probe (ST_PR_RD only off the edge), then ST_POP_RD,
// ST_POP_LBL and ST_POP_LBLW per frontier pop, then ST_TR_W plus probes per traced path step.
// One request is in flight at a time; the next beat is taken once the result leaves.
// Reset (aresetn low, synchronous) clears control, status and config; memories keep data.
module grid_maze_path_search_unit #(
    parameter int GRID_DIM = gmps_pkg::GRID_DIM_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [5:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // cell_row[4:0], cell_col[9:5], cell_blocked[10], step_index[20:11]
    input  logic [1:0]  s_tuser,  // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // path_found[0], path_length[10:1], step_row[15:11], step_col[20:16]
    output logic [0:0]  m_tuser   // step_valid[0]
);

    localparam int AW = $clog2(GRID_DIM * GRID_DIM);
    localparam int LW = gmps_pkg::LABEL_W;
    localparam int SW = gmps_pkg::STORE_AW;
    localparam logic [5:0] SPAN_CAP = 6'(GRID_DIM < gmps_pkg::SPAN_MAX ?
                                          GRID_DIM : gmps_pkg::SPAN_MAX);
    localparam logic [8:0] DIM_W = 9'(GRID_DIM);

    typedef enum logic [3:0] {
        ST_IDLE, ST_PATH_RD, ST_RUN_INIT, ST_PR_RD, ST_PR_CHK,
        ST_POP_RD, ST_POP_LBL, ST_POP_LBLW, ST_TR_W
    } state_t;

    function automatic logic [AW-1:0] cell_addr(input logic [4:0] r, input logic [4:0] c);
        logic [AW+5:0] a;
        a = (AW+6)'(r) * (AW+6)'(GRID_DIM) + (AW+6)'(c);
        return a[AW-1:0];
    endfunction

    state_t state_reg, state_next;
    logic [5:0] rows_reg, cols_reg;
    logic [4:0] sr_reg, sc_reg, er_reg, ec_reg;
    logic       mode_reg;

    logic       found_reg, found_next;
    logic [9:0] len_reg, len_next;
    logic [4:0] cur_r_reg, cur_r_next, cur_c_reg, cur_c_next;
    logic [LW-1:0] cur_lbl_reg, cur_lbl_next;
    logic [1:0] dir_reg, dir_next;
    logic       trace_reg, trace_next;
    logic [9:0] j_reg, j_next;
    logic [10:0] cnt_reg, cnt_next;
    logic [9:0] head_reg, head_next;
    logic       mv_reg, mv_next;
    logic [23:0] md_reg, md_next;
    logic       mu_reg, mu_next;

    logic          g_we;
    logic [AW-1:0] g_waddr, g_raddr;
    logic [LW-1:0] g_wdata, g_rdata;
    logic          f_we;
    logic [SW-1:0] f_waddr, f_raddr;
    logic [9:0]    f_wdata, f_rdata;
    logic          p_we;
    logic [SW-1:0] p_waddr, p_raddr;
    logic [9:0]    p_wdata, p_rdata;

    gmps_ram #(.DEPTH(GRID_DIM * GRID_DIM), .WIDTH(LW)) u_grid (
        .aclk(aclk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
        .raddr(g_raddr), .rdata(g_rdata)
    );
    gmps_ram #(.DEPTH(gmps_pkg::STORE_DEPTH), .WIDTH(10)) u_frontier (
        .aclk(aclk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata)
    );
    gmps_ram #(.DEPTH(gmps_pkg::STORE_DEPTH), .WIDTH(10)) u_path (
        .aclk(aclk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    logic [5:0] span_r, span_c;
    logic       nb_ok;
    logic [4:0] nb_r, nb_c;
    logic       accept;
    logic [4:0] in_r, in_c;
    logic [9:0] in_idx;
    logic [LW-1:0] new_lbl;
    logic [LW-1:0] len_raw;

    assign span_r = (rows_reg > SPAN_CAP) ? SPAN_CAP : rows_reg;
    assign span_c = (cols_reg > SPAN_CAP) ? SPAN_CAP : cols_reg;
    assign s_tready = (state_reg == ST_IDLE) && !mv_reg;
    assign accept = s_tvalid && s_tready;
    assign in_r = s_tdata[4:0];
    assign in_c = s_tdata[9:5];
    assign in_idx = s_tdata[20:11];
    assign new_lbl = cur_lbl_reg + 11'd1;
    assign len_raw = new_lbl - gmps_pkg::LABEL_BASE;
    assign m_tvalid = mv_reg;
    assign m_tdata = md_reg;
    assign m_tuser = mu_reg;

    always_comb begin
        nb_r = cur_r_reg;
        nb_c = cur_c_reg;
        nb_ok = 1'b0;
        case (dir_reg)
            gmps_pkg::DIR_RIGHT: begin
                nb_c = cur_c_reg + 5'd1;
                nb_ok = (6'(cur_c_reg) + 6'd1) < span_c;
            end
            gmps_pkg::DIR_DOWN: begin
                nb_r = cur_r_reg + 5'd1;
                nb_ok = (6'(cur_r_reg) + 6'd1) < span_r;
            end
            gmps_pkg::DIR_LEFT: begin
                nb_c = cur_c_reg - 5'd1;
                nb_ok = cur_c_reg != 5'd0;
            end
            default: begin
                nb_r = cur_r_reg - 5'd1;
                nb_ok = cur_r_reg != 5'd0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        found_next = found_reg;
        len_next = len_reg;
        cur_r_next = cur_r_reg;
        cur_c_next = cur_c_reg;
        cur_lbl_next = cur_lbl_reg;
        dir_next = dir_reg;
        trace_next = trace_reg;
        j_next = j_reg;
        cnt_next = cnt_reg;
        head_next = head_reg;
        mv_next = mv_reg && !m_tready;
        md_next = md_reg;
        mu_next = mu_reg;
        g_we = 1'b0;
        g_waddr = cell_addr(nb_r, nb_c);
        g_wdata = new_lbl;
        g_raddr = cell_addr(nb_r, nb_c);
        f_we = 1'b0;
        f_waddr = head_reg + cnt_reg[9:0];
        f_wdata = {nb_r, nb_c};
        f_raddr = mode_reg ? (head_reg + cnt_reg[9:0] - 10'd1) : head_reg;
        p_we = 1'b0;
        p_waddr = j_reg;
        p_wdata = {cur_r_reg, cur_c_reg};
        p_raddr = in_idx;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_tuser)
                        gmps_pkg::REQ_WRITE: begin
                            g_we = ({4'd0, in_r} < DIM_W) && ({4'd0, in_c} < DIM_W);
                            g_waddr = cell_addr(in_r, in_c);
                            g_wdata = LW'(s_tdata[10]);
                            mv_next = 1'b1;
                            md_next = {13'd0, len_reg, found_reg};
                            mu_next = 1'b0;
                        end
                        gmps_pkg::REQ_RUN: state_next = ST_RUN_INIT;
                        gmps_pkg::REQ_READ: begin
                            if (in_idx < len_reg) begin
                                state_next = ST_PATH_RD;
                            end else begin
                                mv_next = 1'b1;
                                md_next = {13'd0, len_reg, found_reg};
                                mu_next = 1'b0;
                            end
                        end
                        default: begin
                            mv_next = 1'b1;
                            md_next = {13'd0, len_reg, found_reg};
                            mu_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_PATH_RD: begin
                mv_next = 1'b1;
                md_next = {3'd0, p_rdata[4:0], p_rdata[9:5], len_reg, found_reg};
                mu_next = 1'b1;
                state_next = ST_IDLE;
            end
            ST_RUN_INIT: begin
                len_next = 10'd0;
                if (sr_reg == er_reg && sc_reg == ec_reg) begin
                    found_next = 1'b1;
                    mv_next = 1'b1;
                    md_next = {23'd0, 1'b1};
                    mu_next = 1'b0;
                    state_next = ST_IDLE;
                end else if (!(6'(sr_reg) < span_r && 6'(sc_reg) < span_c)) begin
                    found_next = 1'b0;
                    mv_next = 1'b1;
                    md_next = 24'd0;
                    mu_next = 1'b0;
                    state_next = ST_IDLE;
                end else begin
                    g_we = 1'b1;
                    g_waddr = cell_addr(sr_reg, sc_reg);
                    g_wdata = gmps_pkg::LABEL_BASE;
                    cur_r_next = sr_reg;
                    cur_c_next = sc_reg;
                    cur_lbl_next = gmps_pkg::LABEL_BASE;
                    cnt_next = 11'd0;
                    head_next = 10'd0;
                    dir_next = gmps_pkg::DIR_RIGHT;
                    trace_next = 1'b0;
                    state_next = ST_PR_RD;
                end
            end
            ST_PR_RD: begin
                if (nb_ok) begin
                    state_next = ST_PR_CHK;
                end else if (dir_reg != gmps_pkg::DIR_UP) begin
                    dir_next = dir_reg + 2'd1;
                end else if (trace_reg) begin
                    if (j_reg == 10'd0) begin
                        found_next = 1'b1;
                        mv_next = 1'b1;
                        md_next = {13'd0, len_reg, 1'b1};
                        mu_next = 1'b0;
                        state_next = ST_IDLE;
                    end else begin
                        j_next = j_reg - 10'd1;
                        state_next = ST_TR_W;
                    end
                end else begin
                    state_next = ST_POP_RD;
                end
            end
            ST_PR_CHK: begin
                if (trace_reg) begin
                    if (g_rdata == LW'(j_reg) + gmps_pkg::LABEL_BASE ||
                        dir_reg == gmps_pkg::DIR_UP) begin
                        if (g_rdata == LW'(j_reg) + gmps_pkg::LABEL_BASE) begin
                            cur_r_next = nb_r;
                            cur_c_next = nb_c;
                        end
                        if (j_reg == 10'd0) begin
                            found_next = 1'b1;
                            mv_next = 1'b1;
                            md_next = {13'd0, len_reg, 1'b1};
                            mu_next = 1'b0;
                            state_next = ST_IDLE;
                        end else begin
                            j_next = j_reg - 10'd1;
                            state_next = ST_TR_W;
                        end
                    end else begin
                        dir_next = dir_reg + 2'd1;
                        state_next = ST_PR_RD;
                    end
                end else begin
                    state_next = (dir_reg == gmps_pkg::DIR_UP) ? ST_POP_RD : ST_PR_RD;
                    dir_next = dir_reg + 2'd1;
                    if (g_rdata == gmps_pkg::LABEL_OPEN) begin
                        g_we = 1'b1;
                        if (nb_r == er_reg && nb_c == ec_reg) begin
                            trace_next = 1'b1;
                            cur_r_next = er_reg;
                            cur_c_next = ec_reg;
                            if (new_lbl < gmps_pkg::LABEL_BASE || len_raw == 11'd0) begin
                                len_next = 10'd0;
                                found_next = 1'b1;
                                mv_next = 1'b1;
                                md_next = {23'd0, 1'b1};
                                mu_next = 1'b0;
                                state_next = ST_IDLE;
                            end else begin
                                len_next = len_raw[10] ? 10'd1023 : len_raw[9:0];
                                j_next = (len_raw[10] ? 10'd1023 : len_raw[9:0]) - 10'd1;
                                state_next = ST_TR_W;
                            end
                        end else if (!cnt_reg[10]) begin
                            f_we = 1'b1;
                            cnt_next = cnt_reg + 11'd1;
                        end
                    end
                end
            end
            ST_POP_RD: begin
                if (cnt_reg == 11'd0) begin
                    found_next = 1'b0;
                    len_next = 10'd0;
                    mv_next = 1'b1;
                    md_next = 24'd0;
                    mu_next = 1'b0;
                    state_next = ST_IDLE;
                end else begin
                    if (!mode_reg) begin
                        head_next = head_reg + 10'd1;
                    end
                    cnt_next = cnt_reg - 11'd1;
                    state_next = ST_POP_LBL;
                end
            end
            ST_POP_LBL: begin
                cur_r_next = f_rdata[9:5];
                cur_c_next = f_rdata[4:0];
                g_raddr = cell_addr(f_rdata[9:5], f_rdata[4:0]);
                state_next = ST_POP_LBLW;
            end
            ST_POP_LBLW: begin
                cur_lbl_next = g_rdata;
                dir_next = gmps_pkg::DIR_RIGHT;
                state_next = ST_PR_RD;
            end
            ST_TR_W: begin
                p_we = 1'b1;
                dir_next = gmps_pkg::DIR_RIGHT;
                state_next = ST_PR_RD;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rows_reg <= 6'd32;
            cols_reg <= 6'd32;
            sr_reg <= 5'd0;
            sc_reg <= 5'd0;
            er_reg <= 5'd0;
            ec_reg <= 5'd0;
            mode_reg <= 1'b0;
            found_reg <= 1'b0;
            len_reg <= 10'd0;
            cnt_reg <= 11'd0;
            head_reg <= 10'd0;
            trace_reg <= 1'b0;
            dir_reg <= gmps_pkg::DIR_RIGHT;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            found_reg <= found_next;
            len_reg <= len_next;
            cnt_reg <= cnt_next;
            head_reg <= head_next;
            trace_reg <= trace_next;
            dir_reg <= dir_next;
            mv_reg <= mv_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    gmps_pkg::CFG_NUM_ROWS:  rows_reg <= cfg_wdata;
                    gmps_pkg::CFG_NUM_COLS:  cols_reg <= cfg_wdata;
                    gmps_pkg::CFG_START_ROW: sr_reg <= cfg_wdata[4:0];
                    gmps_pkg::CFG_START_COL: sc_reg <= cfg_wdata[4:0];
                    gmps_pkg::CFG_END_ROW:   er_reg <= cfg_wdata[4:0];
                    gmps_pkg::CFG_END_COL:   ec_reg <= cfg_wdata[4:0];
                    gmps_pkg::CFG_MODE:      mode_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
        end
        cur_r_reg <= cur_r_next;
        cur_c_reg <= cur_c_next;
        cur_lbl_reg <= cur_lbl_next;
        j_reg <= j_next;
        md_reg <= md_next;
        mu_reg <= mu_next;
    end

endmodule

// ----- dv/grid_maze_path_search_unit_tb.sv -----
typedef struct packed {
    bit       path_found;
    bit [9:0] path_length;
    bit [4:0] step_row;
    bit [4:0] step_col;
    bit       step_valid;
} route_result_t;

class maze_scoreboard;
    bit [10:0]     labels[1024];
    bit [9:0]      frontier[1024];
    bit [9:0]      route[1024];
    int            fr_head, fr_count;
    bit            found_flag;
    bit [9:0]      route_len;
    bit [5:0]      rows_cfg, cols_cfg;
    bit [4:0]      sr_cfg, sc_cfg, er_cfg, ec_cfg;
    bit            lifo_cfg;
    route_result_t expected_q[$];
    int            errors, n_runs, n_found, n_reads_valid, n_longest;

    function new();
        rows_cfg = 6'd32;
        cols_cfg = 6'd32;
    endfunction

    function void set_reg(bit [2:0] idx, bit [5:0] val);
        case (idx)
            gmps_pkg::CFG_NUM_ROWS:  rows_cfg = val;
            gmps_pkg::CFG_NUM_COLS:  cols_cfg = val;
            gmps_pkg::CFG_START_ROW: sr_cfg = val[4:0];
            gmps_pkg::CFG_START_COL: sc_cfg = val[4:0];
            gmps_pkg::CFG_END_ROW:   er_cfg = val[4:0];
            gmps_pkg::CFG_END_COL:   ec_cfg = val[4:0];
            gmps_pkg::CFG_MODE:      lifo_cfg = val[0];
            default: ;
        endcase
    endfunction

    function bit in_grid(int r, int c);
        int nr_lim, nc_lim;
        nr_lim = (rows_cfg > gmps_pkg::SPAN_MAX) ? gmps_pkg::SPAN_MAX : int'(rows_cfg);
        nc_lim = (cols_cfg > gmps_pkg::SPAN_MAX) ? gmps_pkg::SPAN_MAX : int'(cols_cfg);
        return r >= 0 && c >= 0 && r < nr_lim && c < nc_lim;
    endfunction

    function void neighbor(int d, int r, int c, output int nr, output int nc);
        nr = r;
        nc = c;
        case (d[1:0])
            gmps_pkg::DIR_RIGHT: nc = c + 1;
            gmps_pkg::DIR_DOWN:  nr = r + 1;
            gmps_pkg::DIR_LEFT:  nc = c - 1;
            gmps_pkg::DIR_UP:    nr = r - 1;
            default: ;
        endcase
    endfunction

    // true when the end cell gets labeled, or when start equals end
    function bit flood(output bit [9:0] len_out);
        int hr, hc, nr, nc, len, slot;
        bit done;
        len_out = '0;
        done = 0;
        if (sr_cfg == er_cfg && sc_cfg == ec_cfg) return 1;
        if (!in_grid(int'(sr_cfg), int'(sc_cfg))) return 0;
        fr_head = 0;
        fr_count = 0;
        labels[sr_cfg*32 + sc_cfg] = gmps_pkg::LABEL_BASE;
        hr = int'(sr_cfg);
        hc = int'(sc_cfg);
        forever begin
            for (int d = 0; d < 4; d++) begin
                neighbor(d, hr, hc, nr, nc);
                if (in_grid(nr, nc) && labels[nr*32 + nc] == gmps_pkg::LABEL_OPEN) begin
                    labels[nr*32 + nc] = labels[hr*32 + hc] + 11'd1;
                    if (nr == er_cfg && nc == ec_cfg) begin
                        done = 1;
                        break;
                    end
                    if (fr_count < gmps_pkg::STORE_DEPTH) begin
                        frontier[(fr_head + fr_count) % gmps_pkg::STORE_DEPTH] =
                            10'(nr*32 + nc);
                        fr_count++;
                    end
                end
            end
            if (done) break;
            if (fr_count == 0) return 0;
            if (lifo_cfg) begin
                slot = (fr_head + fr_count - 1) % gmps_pkg::STORE_DEPTH;
            end else begin
                slot = fr_head;
                fr_head = (fr_head + 1) % gmps_pkg::STORE_DEPTH;
            end
            fr_count--;
            hr = int'(frontier[slot][9:5]);
            hc = int'(frontier[slot][4:0]);
        end
        len = int'(labels[er_cfg*32 + ec_cfg]) - 2;
        if (len < 0) len = 0;
        if (len > 1023) len = 1023;
        len_out = 10'(len);
        hr = int'(er_cfg);
        hc = int'(ec_cfg);
        for (int j = len - 1; j >= 0; j--) begin
            route[j] = 10'(hr*32 + hc);
            for (int d = 0; d < 4; d++) begin
                neighbor(d, hr, hc, nr, nc);
                if (in_grid(nr, nc) && labels[nr*32 + nc] == j + 2) begin
                    hr = nr;
                    hc = nc;
                    break;
                end
            end
        end
        return 1;
    endfunction

    function void note_input(bit [1:0] req, bit [4:0] r, bit [4:0] c, bit blk,
                             bit [9:0] idx);
        route_result_t res;
        res = '0;
        case (req)
            gmps_pkg::REQ_WRITE: labels[r*32 + c] = 11'(blk);
            gmps_pkg::REQ_RUN: begin
                found_flag = flood(route_len);
                if (!found_flag) route_len = '0;
                n_runs++;
                n_found += found_flag;
                if (route_len > n_longest) n_longest = route_len;
            end
            gmps_pkg::REQ_READ: begin
                if (idx < route_len) begin
                    res.step_row = route[idx][9:5];
                    res.step_col = route[idx][4:0];
                    res.step_valid = 1;
                    n_reads_valid++;
                end
            end
            default: ;
        endcase
        res.path_found = found_flag;
        res.path_length = route_len;
        expected_q = {expected_q, res};
    endfunction

    function void check(route_result_t act);
        route_result_t exp_r;
        if (expected_q.size() == 0) begin
            $error("result beat with nothing expected");
            errors++;
            return;
        end
        exp_r = expected_q.pop_front();
        if (act.path_found != exp_r.path_found) begin
            $error("path_found exp %0d got %0d", exp_r.path_found, act.path_found);
            errors++;
        end
        if (act.path_length != exp_r.path_length) begin
            $error("path_length exp %0d got %0d", exp_r.path_length, act.path_length);
            errors++;
        end
        if (act.step_row != exp_r.step_row) begin
            $error("step_row exp %0d got %0d", exp_r.step_row, act.step_row);
            errors++;
        end
        if (act.step_col != exp_r.step_col) begin
            $error("step_col exp %0d got %0d", exp_r.step_col, act.step_col);
            errors++;
        end
        if (act.step_valid != exp_r.step_valid) begin
            $error("step_valid exp %0d got %0d", exp_r.step_valid, act.step_valid);
            errors++;
        end
    endfunction
endclass

module grid_maze_path_search_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 200000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [5:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;

    maze_scoreboard sb;
    int  src_idle_pct, snk_idle_pct;
    int  beats_in, random_items;
    bit  hold_req;
    int  quiet_cycles;

    grid_maze_path_search_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    // result side: random backpressure plus one long hold
    initial begin
        m_tready = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 0;
                m_tready = 0;
                repeat (400) @(negedge aclk);
            end
            m_tready = ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge aclk) begin
        route_result_t act;
        if (aresetn && m_tvalid && m_tready) begin
            act.path_found  = m_tdata[0];
            act.path_length = m_tdata[10:1];
            act.step_row    = m_tdata[15:11];
            act.step_col    = m_tdata[20:16];
            act.step_valid  = m_tuser[0];
            sb.check(act);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("grid_maze_path_search_unit regression: fail");
                $finish;
            end
        end
    end

    task automatic send_beat(bit [1:0] req, bit [4:0] r, bit [4:0] c, bit blk,
                             bit [9:0] idx);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid = 0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid = 1;
        s_tuser  = req;
        s_tdata  = {3'b0, idx, blk, c, r};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(req, r, c, blk, idx);
        beats_in++;
        if (req != gmps_pkg::REQ_UNUSED) random_items++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid = 0;
        @(negedge aclk);
        while (sb.expected_q.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic set_regs(bit [5:0] rows, bit [5:0] cols, bit [4:0] sr, bit [4:0] sc,
                            bit [4:0] er, bit [4:0] ec, bit mode);
        bit [5:0] vals[7];
        drain();
        vals = '{rows, cols, {1'b0, sr}, {1'b0, sc}, {1'b0, er}, {1'b0, ec}, {5'b0, mode}};
        for (int i = 0; i < 7; i++) begin
            cfg_wr_en = 1;
            cfg_index = i[2:0];
            cfg_wdata = vals[i];
            sb.set_reg(i[2:0], vals[i]);
            @(negedge aclk);
        end
        cfg_wr_en = 0;
    endtask

    task automatic reload(int wall_pct, bit start_wall);
        int nr, nc;
        bit blk;
        nr = (sb.rows_cfg > 32) ? 32 : int'(sb.rows_cfg);
        nc = (sb.cols_cfg > 32) ? 32 : int'(sb.cols_cfg);
        for (int r = 0; r < nr; r++)
            for (int c = 0; c < nc; c++) begin
                if (r == sb.sr_cfg && c == sb.sc_cfg) blk = start_wall;
                else if (r == sb.er_cfg && c == sb.ec_cfg) blk = 0;
                else blk = ($urandom_range(99) < wall_pct);
                send_beat(gmps_pkg::REQ_WRITE, 5'(r), 5'(c), blk, 10'($urandom));
            end
    endtask

    task automatic read_steps(int n);
        bit [9:0] idx;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(5))
                0: idx = 10'($urandom);
                1: idx = sb.route_len;
                2: idx = (sb.route_len == 0) ? 10'd0 : sb.route_len - 10'd1;
                default: idx = 10'($urandom_range(sb.route_len));
            endcase
            send_beat(gmps_pkg::REQ_READ, 5'($urandom), 5'($urandom), 1'($urandom), idx);
        end
    endtask

    task automatic noise();
        case ($urandom_range(2))
            0: send_beat(gmps_pkg::REQ_UNUSED, 5'($urandom), 5'($urandom), 1'($urandom),
                         10'($urandom));
            1: send_beat(gmps_pkg::REQ_WRITE, 5'($urandom), 5'($urandom), 1'($urandom),
                         10'($urandom));
            default: send_beat(gmps_pkg::REQ_READ, 5'($urandom), 5'($urandom), 1'($urandom),
                               10'($urandom));
        endcase
    endtask

    initial begin
        int phase, dim_r, dim_c, sel;
        bit [4:0] sr, sc, er, ec;
        sb = new();
        aresetn = 0;
        cfg_wr_en = 0;
        cfg_index = 0;
        cfg_wdata = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tuser = 0;
        hold_req = 0;
        quiet_cycles = 0;
        src_idle_pct = 8;
        snk_idle_pct = 80;
        repeat (12) @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        // directed: reset defaults give start == end, then idle status reads
        send_beat(gmps_pkg::REQ_RUN, 5'd0, 5'd0, 1'b0, 10'd0);
        send_beat(gmps_pkg::REQ_READ, 5'd0, 5'd0, 1'b0, 10'd0);
        send_beat(gmps_pkg::REQ_READ, 5'd31, 5'd31, 1'b1, 10'd1023);
        send_beat(gmps_pkg::REQ_UNUSED, 5'd31, 5'd31, 1'b1, 10'd1023);
        send_beat(gmps_pkg::REQ_WRITE, 5'd31, 5'd31, 1'b1, 10'd1023);
        set_regs(6'd4, 6'd4, 5'd0, 5'd0, 5'd3, 5'd3, 1'b0);
        reload(0, 0);
        send_beat(gmps_pkg::REQ_RUN, 5'd0, 5'd0, 1'b0, 10'd0);
        read_steps(3);
        send_beat(gmps_pkg::REQ_RUN, 5'd0, 5'd0, 1'b0, 10'd0);   // stale labels block everything
        set_regs(6'd4, 6'd4, 5'd1, 5'd1, 5'd3, 5'd0, 1'b1);
        reload(20, 1);                                           // start on a wall
        send_beat(gmps_pkg::REQ_RUN, 5'd0, 5'd0, 1'b0, 10'd0);
        read_steps(2);
        set_regs(6'd4, 6'd4, 5'd10, 5'd1, 5'd2, 5'd2, 1'b0);     // start outside the grid
        send_beat(gmps_pkg::REQ_RUN, 5'd0, 5'd0, 1'b0, 10'd0);
        send_beat(gmps_pkg::REQ_READ, 5'd0, 5'd0, 1'b0, 10'd0);
        set_regs(6'd0, 6'd0, 5'd0, 5'd0, 5'd1, 5'd1, 1'b0);      // empty grid
        send_beat(gmps_pkg::REQ_RUN, 5'd0, 5'd0, 1'b0, 10'd0);

        random_items = 0;
        phase = 0;
        while (random_items < 1700) begin
            if (random_items < 570) begin
                src_idle_pct = 8;
                snk_idle_pct = 80;
            end else if (random_items < 1140) begin
                src_idle_pct = 80;
                snk_idle_pct = 8;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            sel = $urandom_range(99);
            if (phase == 5) begin
                dim_r = 32;
                dim_c = 32;
            end else if (sel < 75) begin
                dim_r = $urandom_range(1, 7);
                dim_c = $urandom_range(1, 7);
            end else begin
                dim_r = $urandom_range(1, 16);
                dim_c = $urandom_range(1, 16);
            end
            sr = 5'($urandom_range(dim_r - 1));
            sc = 5'($urandom_range(dim_c - 1));
            er = 5'($urandom_range(dim_r - 1));
            ec = 5'($urandom_range(dim_c - 1));
            sel = $urandom_range(99);
            if (sel < 6) begin
                er = sr;
                ec = sc;
            end else if (sel < 12) begin
                sr = 5'($urandom);
                er = 5'($urandom);
            end
            set_regs((phase % 14 == 9) ? 6'd63 : dim_r[5:0], dim_c[5:0],
                     sr, sc, er, ec, 1'($urandom));
            reload($urandom_range(5, 40), ($urandom_range(19) == 0));
            if (phase == 2) hold_req = 1;
            if ($urandom_range(3) == 0) noise();
            send_beat(gmps_pkg::REQ_RUN, 5'($urandom), 5'($urandom), 1'($urandom),
                      10'($urandom));
            read_steps($urandom_range(2, 8));
            if ($urandom_range(5) == 0) begin
                send_beat(gmps_pkg::REQ_RUN, 5'd0, 5'd0, 1'b0, 10'd0);
                read_steps(1);
            end
            if ($urandom_range(3) == 0) noise();
            phase++;
        end

        drain();
        repeat (50) @(negedge aclk);
        $display("covered %0d beats, %0d searches (%0d found, longest %0d steps)",
                 beats_in, sb.n_runs, sb.n_found, sb.n_longest);
        $display("%0d valid step reads, FIFO and LIFO, grids from empty to 32x32",
                 sb.n_reads_valid);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("grid_maze_path_search_unit regression: pass");
        end else begin
            $display("grid_maze_path_search_unit regression: fail");
        end
        $finish;
    end
endmodule
